[rtl/sabc_pkg.sv]
`default_nettype none

package sabc_pkg;

   localparam int MAX_DIM_DEFAULT = 2048;

   localparam int CHAN_W   = 8;
   localparam int COORD_W  = 11;
   localparam int CSR_W    = 12;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_DEST_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;

   localparam logic [CSR_W-1:0] SPRITE_DIM_RESET    = 12'd16;
   localparam logic [CSR_W-1:0] SCREEN_WIDTH_RESET  = 12'd640;
   localparam logic [CSR_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

   // one queued pixel that survived clipping
   typedef struct packed {
      logic                opaque;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [CHAN_W-1:0]   src_red;
      logic [CHAN_W-1:0]   src_green;
      logic [CHAN_W-1:0]   src_blue;
      logic [CHAN_W-1:0]   src_alpha;
      logic [CHAN_W-1:0]   bg_red;
      logic [CHAN_W-1:0]   bg_green;
      logic [CHAN_W-1:0]   bg_blue;
   } pix_type;

endpackage

`default_nettype wire

[rtl/sabc_front.sv]
`default_nettype none

module sabc_front #(
   parameter int MAX_DIM = sabc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [sabc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sabc_pkg::CSR_W-1:0]     csr_wdata,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [sabc_pkg::REQ_DATA_W-1:0] req_tdata,
   output      logic                          push_valid,
   input  wire logic                          push_ready,
   output      sabc_pkg::pix_type             push_data
);
   import sabc_pkg::*;

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = (CW + 1 > CSR_W) ? CW + 1 : CSR_W;
   localparam int XW = DW + 1;

   logic [CSR_W-1:0] dest_x_ff, dest_y_ff;
   logic [CSR_W-1:0] sprite_width_ff, sprite_height_ff;
   logic [CSR_W-1:0] screen_width_ff, screen_height_ff;
   logic [CW-1:0]    col_count_ff, col_count_in;
   logic [CW-1:0]    row_count_ff, row_count_in;

   logic [DW-1:0] sw, sh, scw, sch;
   logic [XW-1:0] pos_x, pos_y;
   logic          on_screen, keep, accept;
   logic [CHAN_W-1:0] alpha;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff        <= '0;
         dest_y_ff        <= '0;
         sprite_width_ff  <= SPRITE_DIM_RESET;
         sprite_height_ff <= SPRITE_DIM_RESET;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEST_X:        dest_x_ff        <= csr_wdata;
            CSR_DEST_Y:        dest_y_ff        <= csr_wdata;
            CSR_SPRITE_WIDTH:  sprite_width_ff  <= csr_wdata;
            CSR_SPRITE_HEIGHT: sprite_height_ff <= csr_wdata;
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // size clamps: a zero sprite size acts as one
   always_comb begin
      sw  = (sprite_width_ff == '0) ? DW'(1) :
            (DW'(sprite_width_ff) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(sprite_width_ff);
      sh  = (sprite_height_ff == '0) ? DW'(1) :
            (DW'(sprite_height_ff) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(sprite_height_ff);
      scw = (DW'(screen_width_ff) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(screen_width_ff);
      sch = (DW'(screen_height_ff) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(screen_height_ff);
   end

   assign pos_x = {{(XW-CSR_W){dest_x_ff[CSR_W-1]}}, dest_x_ff}
                + {{(XW-CW){1'b0}}, col_count_ff};
   assign pos_y = {{(XW-CSR_W){dest_y_ff[CSR_W-1]}}, dest_y_ff}
                + {{(XW-CW){1'b0}}, row_count_ff};

   assign alpha     = req_tdata[4*CHAN_W-1:3*CHAN_W];
   assign on_screen = !pos_x[XW-1] && (pos_x[DW-1:0] < scw)
                   && !pos_y[XW-1] && (pos_y[DW-1:0] < sch);
   assign keep      = on_screen && (alpha != ALPHA_CLEAR);

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = req_tvalid && keep;

   always_comb begin
      push_data.opaque    = (alpha == ALPHA_OPAQUE);
      push_data.col       = pos_x[COORD_W-1:0];
      push_data.row       = pos_y[COORD_W-1:0];
      push_data.src_red   = req_tdata[CHAN_W-1:0];
      push_data.src_green = req_tdata[2*CHAN_W-1:CHAN_W];
      push_data.src_blue  = req_tdata[3*CHAN_W-1:2*CHAN_W];
      push_data.src_alpha = alpha;
      push_data.bg_red    = req_tdata[5*CHAN_W-1:4*CHAN_W];
      push_data.bg_green  = req_tdata[6*CHAN_W-1:5*CHAN_W];
      push_data.bg_blue   = req_tdata[7*CHAN_W-1:6*CHAN_W];
   end

   // raster counters; a count past a shrunken size wraps on the next word
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (({{(DW-CW){1'b0}}, col_count_ff} + DW'(1)) >= sw) begin
            col_count_in = '0;
            if (({{(DW-CW){1'b0}}, row_count_ff} + DW'(1)) >= sh) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_count_ff + CW'(1);
            end
         end else begin
            col_count_in = col_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sabc_queue.sv]
`default_nettype none

module sabc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output      logic              push_ready,
   input  wire sabc_pkg::pix_type push_data,
   output      logic              pop_valid,
   input  wire logic              pop_ready,
   output      sabc_pkg::pix_type pop_data
);
   import sabc_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   pix_type          entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != (PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/sabc_back.sv]
`default_nettype none

module sabc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output      logic              pop_ready,
   input  wire sabc_pkg::pix_type pop_data,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [sabc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sabc_pkg::*;

   localparam int PROD_W = 2 * CHAN_W;

   // floor(v / 255) for v up to 255*255
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] v);
      logic [PROD_W:0] t;
      t = {1'b0, v} + (PROD_W+1)'(1) + {{(CHAN_W+1){1'b0}}, v[PROD_W-1:CHAN_W]};
      return t[PROD_W-1:CHAN_W];
   endfunction

   logic                advance;
   logic                s1_valid_ff;
   logic                s1_opaque_ff;
   logic [COORD_W-1:0]  s1_col_ff, s1_row_ff;
   logic [CHAN_W-1:0]   s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [PROD_W-1:0]   s1_sr_ff, s1_sg_ff, s1_sb_ff;
   logic [PROD_W-1:0]   s1_br_ff, s1_bg_ff, s1_bb_ff;
   logic [CHAN_W-1:0]   inv_alpha;
   logic [CHAN_W-1:0]   red, green, blue;
   logic                out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   assign advance   = !out_valid_ff || rsp_tready;
   assign pop_ready = advance;
   assign inv_alpha = ALPHA_OPAQUE - pop_data.src_alpha;

   // stage 1: per-channel products
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_opaque_ff <= pop_data.opaque;
         s1_col_ff    <= pop_data.col;
         s1_row_ff    <= pop_data.row;
         s1_red_ff    <= pop_data.src_red;
         s1_green_ff  <= pop_data.src_green;
         s1_blue_ff   <= pop_data.src_blue;
         s1_sr_ff     <= PROD_W'(pop_data.src_red)   * PROD_W'(pop_data.src_alpha);
         s1_sg_ff     <= PROD_W'(pop_data.src_green) * PROD_W'(pop_data.src_alpha);
         s1_sb_ff     <= PROD_W'(pop_data.src_blue)  * PROD_W'(pop_data.src_alpha);
         s1_br_ff     <= PROD_W'(pop_data.bg_red)    * PROD_W'(inv_alpha);
         s1_bg_ff     <= PROD_W'(pop_data.bg_green)  * PROD_W'(inv_alpha);
         s1_bb_ff     <= PROD_W'(pop_data.bg_blue)   * PROD_W'(inv_alpha);
      end
   end

   // stage 2: sum, divide by 255, pack; opaque pixels copy the source
   always_comb begin
      if (s1_opaque_ff) begin
         red   = s1_red_ff;
         green = s1_green_ff;
         blue  = s1_blue_ff;
      end else begin
         red   = div255(s1_sr_ff + s1_br_ff);
         green = div255(s1_sg_ff + s1_bg_ff);
         blue  = div255(s1_sb_ff + s1_bb_ff);
      end
      out_data_in = {{(RSP_DATA_W - 2*COORD_W - 4*CHAN_W){1'b0}},
                     ALPHA_OPAQUE, red, green, blue, s1_row_ff, s1_col_ff};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop_valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

[rtl/sprite_alpha_blend_clip.sv]
`default_nettype none

// Sprite compositor. Sprite RGBA words arrive in raster order, each with the
// background RGB at its target spot; column and row counters plus the signed
// destination give the screen position. Off-screen and alpha-0 pixels make no
// output word; the rest leave blended over the background (alpha 255 copies
// the source) as ARGB with alpha 0xFF, tagged with screen column and row.
// Throughput is one word per clock while the queue has room: the front clips
// and classifies in the accepting cycle and feeds a 4-entry queue, the back
// is a two-stage multiply / divide-by-255 pipeline with an output register;
// a word passes the queue, stage 1 and the output register. The user writes
// registers via csr_we/csr_index/csr_wdata only while idle; not enforced.

module sprite_alpha_blend_clip #(
   parameter int MAX_DIM = sabc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [sabc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sabc_pkg::CSR_W-1:0]      csr_wdata,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // src_red, src_green, src_blue, src_alpha, bg_red, bg_green, bg_blue
   input  wire logic [sabc_pkg::REQ_DATA_W-1:0] req_tdata,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // screen_col[10:0], screen_row[21:11], pixel_word[53:22], zero pad
   output      logic [sabc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sabc_pkg::*;

   logic    push_valid, push_ready;
   pix_type push_data;
   logic    pop_valid, pop_ready;
   pix_type pop_data;

   sabc_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sabc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   sabc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[tb/sabc_checker.sv]
module sabc_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [sabc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sabc_pkg::CSR_W-1:0]      csr_wdata,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   // src_red, src_green, src_blue, src_alpha, bg_red, bg_green, bg_blue
   input  wire logic [sabc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // screen_col[10:0], screen_row[21:11], pixel_word[53:22], zero pad
   input  wire logic [sabc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                                   mismatches,
   output int                                   pending
);
   import sabc_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [31:0]        pixel;
   } screen_px_type;

   int               dest_x;
   int               dest_y;
   logic [CSR_W-1:0] sprite_w;
   logic [CSR_W-1:0] sprite_h;
   logic [CSR_W-1:0] screen_w;
   logic [CSR_W-1:0] screen_h;
   int               col_count;
   int               row_count;
   screen_px_type    pending_pixels[$];

   // zero acts as one, anything above the max acts as the max
   function automatic int sprite_extent(input logic [CSR_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_DIM_DEFAULT)
         return MAX_DIM_DEFAULT;
      return int'(v);
   endfunction

   function automatic int screen_extent(input logic [CSR_W-1:0] v);
      if (v > MAX_DIM_DEFAULT)
         return MAX_DIM_DEFAULT;
      return int'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] mix_channel(input int s, input int b, input int a);
      int v;
      v = (s * a + b * (255 - a)) / 255;
      return v[CHAN_W-1:0];
   endfunction

   // returns 1 when the pixel lands on screen and is not transparent
   function automatic bit composite(input logic [REQ_DATA_W-1:0] word,
                                    output screen_px_type px);
      logic [CHAN_W-1:0] sr, sg, sb, sa, br, bgc, bb;
      logic [CHAN_W-1:0] r, g, b;
      int                x, y;
      {bb, bgc, br, sa, sb, sg, sr} = word;
      px = '0;
      x = dest_x + col_count;
      y = dest_y + row_count;
      if (x < 0 || y < 0 || x >= screen_extent(screen_w) || y >= screen_extent(screen_h) ||
          sa == ALPHA_CLEAR)
         return 0;
      if (sa == ALPHA_OPAQUE) begin
         r = sr;
         g = sg;
         b = sb;
      end else begin
         r = mix_channel(sr, br, sa);
         g = mix_channel(sg, bgc, sa);
         b = mix_channel(sb, bb, sa);
      end
      px.col   = x[COORD_W-1:0];
      px.row   = y[COORD_W-1:0];
      px.pixel = {ALPHA_OPAQUE, r, g, b};
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      screen_px_type got;
      screen_px_type want;
      screen_px_type fresh;
      if (reset) begin
         dest_x    = 0;
         dest_y    = 0;
         sprite_w  = SPRITE_DIM_RESET;
         sprite_h  = SPRITE_DIM_RESET;
         screen_w  = SCREEN_WIDTH_RESET;
         screen_h  = SCREEN_HEIGHT_RESET;
         col_count = 0;
         row_count = 0;
         pending_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.col   = rsp_tdata[10:0];
            got.row   = rsp_tdata[21:11];
            got.pixel = rsp_tdata[53:22];
            if (pending_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected word: col %0d row %0d pixel %h",
                           got.col, got.row, got.pixel);
            end else begin
               want = pending_pixels.pop_front();
               if (got.col != want.col || got.row != want.row || got.pixel != want.pixel ||
                   rsp_tdata[RSP_DATA_W-1:54] != '0) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"word mismatch: exp col %0d row %0d pixel %h, ",
                               "got col %0d row %0d pixel %h pad %b"},
                              want.col, want.row, want.pixel,
                              got.col, got.row, got.pixel, rsp_tdata[RSP_DATA_W-1:54]);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DEST_X:        dest_x   = int'($signed(csr_wdata));
               CSR_DEST_Y:        dest_y   = int'($signed(csr_wdata));
               CSR_SPRITE_WIDTH:  sprite_w = csr_wdata;
               CSR_SPRITE_HEIGHT: sprite_h = csr_wdata;
               CSR_SCREEN_WIDTH:  screen_w = csr_wdata;
               CSR_SCREEN_HEIGHT: screen_h = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (composite(req_tdata, fresh))
               pending_pixels.push_back(fresh);
            // counters advance on every word, written or not
            if (col_count + 1 >= sprite_extent(sprite_w)) begin
               col_count = 0;
               if (row_count + 1 >= sprite_extent(sprite_h))
                  row_count = 0;
               else
                  row_count = row_count + 1;
            end else begin
               col_count = col_count + 1;
            end
         end
      end
      pending = pending_pixels.size();
   end

endmodule

[tb/tb.sv]
module tb;
   import sabc_pkg::*;

   localparam int LIMIT        = 500000;
   localparam int RANDOM_ITEMS = 600;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 12;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire [RSP_DATA_W-1:0]  rsp_tdata;

   int mismatches;
   int pending;
   int cycle_count  = 0;
   int random_items = 0;
   int hold_asks    = 0;
   int hold_served  = 0;
   bit steady_sender = 1'b0;

   sprite_alpha_blend_clip i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sabc_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("sprite_alpha_blend_clip regression: fail");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : drain_side
      int ready_run;
      int stall_run;
      int r;
      ready_run = 0;
      stall_run = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_served) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_served++;
         end else begin
            if (ready_run == 0 && stall_run == 0) begin
               r = $urandom_range(0, 9);
               if (r < 4)
                  stall_run = 0;
               else if (r < 7)
                  stall_run = $urandom_range(1, 2);
               else if (r < 9)
                  stall_run = $urandom_range(3, 6);
               else
                  stall_run = $urandom_range(15, 40);
               r = $urandom_range(0, 9);
               if (r < 7)
                  ready_run = $urandom_range(1, 6);
               else
                  ready_run = $urandom_range(20, 120);
            end
            if (stall_run > 0) begin
               rsp_tready = 1'b0;
               stall_run--;
            end else begin
               rsp_tready = 1'b1;
               ready_run--;
            end
         end
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_pixel(
      input logic [CHAN_W-1:0] sr, input logic [CHAN_W-1:0] sg,
      input logic [CHAN_W-1:0] sb, input logic [CHAN_W-1:0] sa,
      input logic [CHAN_W-1:0] br, input logic [CHAN_W-1:0] bgc,
      input logic [CHAN_W-1:0] bb);
      return {bb, bgc, br, sa, sb, sg, sr};
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_pixel(input bit visible);
      logic [CHAN_W-1:0] alpha;
      int                r;
      r = $urandom_range(0, 15);
      case (r)
         0, 1:    alpha = ALPHA_CLEAR;
         2, 3:    alpha = ALPHA_OPAQUE;
         4:       alpha = 8'd1;
         5:       alpha = 8'd254;
         default: alpha = CHAN_W'($urandom_range(0, 255));
      endcase
      if (visible && alpha == ALPHA_CLEAR)
         alpha = 8'd1;
      return pack_pixel(CHAN_W'($urandom()), CHAN_W'($urandom()), CHAN_W'($urandom()),
                        alpha, CHAN_W'($urandom()), CHAN_W'($urandom()),
                        CHAN_W'($urandom()));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [CSR_W-1:0] pick_sprite_dim();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0:       return '0;
         1:       return CSR_W'(MAX_DIM_DEFAULT);
         2:       return CSR_W'($urandom_range(MAX_DIM_DEFAULT + 1, 4095));
         3, 4:    return CSR_W'($urandom_range(9, 40));
         default: return CSR_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_screen_dim();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0:       return '0;
         1:       return CSR_W'(MAX_DIM_DEFAULT);
         2:       return CSR_W'($urandom_range(MAX_DIM_DEFAULT + 1, 4095));
         3:       return CSR_W'($urandom_range(1, MAX_DIM_DEFAULT - 1));
         default: return CSR_W'($urandom_range(1, 48));
      endcase
   endfunction

   // destination mostly straddling the screen so that clipping hits every border
   function automatic logic [CSR_W-1:0] pick_dest(input int sprite_ext, input int screen_ext);
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r == 0)
         return CSR_W'($urandom_range(0, 4095));
      if (r == 1)
         return $urandom_range(0, 1) ? 12'h7FF : 12'h800;
      v = $urandom_range(0, sprite_ext + screen_ext + 2) - sprite_ext - 1;
      return v[CSR_W-1:0];
   endfunction

   function automatic int clamp_dim(input logic [CSR_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_DIM_DEFAULT)
         return MAX_DIM_DEFAULT;
      return int'(v);
   endfunction

   task automatic send_word(input logic [REQ_DATA_W-1:0] data);
      int gap;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // drop valid, wait for every expected word, then let the pipe empty
   task automatic settle();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_setup();
      logic [CSR_W-1:0] sw, sh, scw, sch;
      sw  = pick_sprite_dim();
      sh  = pick_sprite_dim();
      scw = pick_screen_dim();
      sch = pick_screen_dim();
      if ($urandom_range(0, 7) != 0) write_reg(CSR_SPRITE_WIDTH, sw);
      if ($urandom_range(0, 7) != 0) write_reg(CSR_SPRITE_HEIGHT, sh);
      if ($urandom_range(0, 7) != 0) write_reg(CSR_SCREEN_WIDTH, scw);
      if ($urandom_range(0, 7) != 0) write_reg(CSR_SCREEN_HEIGHT, sch);
      if ($urandom_range(0, 7) != 0)
         write_reg(CSR_DEST_X, pick_dest(clamp_dim(sw), clamp_dim(scw)));
      if ($urandom_range(0, 7) != 0)
         write_reg(CSR_DEST_Y, pick_dest(clamp_dim(sh), clamp_dim(sch)));
   endtask

   initial begin : stimulus
      int n;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // reset settings: 16x16 sprite at the origin of a 640x480 screen
      send_word(pack_pixel(8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE, 8'h00, 8'h00, 8'h00));
      send_word(pack_pixel(8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 8'hFF, 8'hFF, 8'hFF));
      send_word(pack_pixel(8'hFF, 8'h80, 8'h01, ALPHA_CLEAR, 8'h12, 8'h34, 8'h56));
      send_word(pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'd1, 8'h00, 8'h00, 8'h00));
      send_word(pack_pixel(8'h00, 8'h00, 8'h00, 8'd254, 8'hFF, 8'hFF, 8'hFF));
      send_word(pack_pixel(8'hAA, 8'h55, 8'hAA, 8'd128, 8'h55, 8'hAA, 8'h55));
      settle();

      // 4x3 sprite hanging off the top-left of a 3x2 screen
      write_reg(CSR_DEST_X, 12'hFFE);
      write_reg(CSR_DEST_Y, 12'hFFF);
      write_reg(CSR_SPRITE_WIDTH, 12'd4);
      write_reg(CSR_SPRITE_HEIGHT, 12'd3);
      write_reg(CSR_SCREEN_WIDTH, 12'd3);
      write_reg(CSR_SCREEN_HEIGHT, 12'd2);
      repeat (12) send_word(random_pixel(1'b1));
      settle();

      // zero sprite size behaves as 1x1
      write_reg(CSR_DEST_X, 12'd0);
      write_reg(CSR_DEST_Y, 12'd0);
      write_reg(CSR_SPRITE_WIDTH, 12'd0);
      write_reg(CSR_SPRITE_HEIGHT, 12'd0);
      repeat (2) send_word(random_pixel(1'b1));
      settle();

      // zero screen size clips everything
      write_reg(CSR_SCREEN_WIDTH, 12'd0);
      repeat (2) send_word(random_pixel(1'b1));
      settle();
      write_reg(CSR_SCREEN_WIDTH, 12'd5);
      write_reg(CSR_SCREEN_HEIGHT, 12'd0);
      repeat (2) send_word(random_pixel(1'b1));
      settle();

      // oversize sprite and screen, destination at both extremes
      write_reg(CSR_SPRITE_WIDTH, 12'hFFF);
      write_reg(CSR_SPRITE_HEIGHT, 12'hFFF);
      write_reg(CSR_SCREEN_WIDTH, 12'hFFF);
      write_reg(CSR_SCREEN_HEIGHT, 12'hFFF);
      write_reg(CSR_DEST_X, 12'h7FF);
      write_reg(CSR_DEST_Y, 12'h7FF);
      repeat (2) send_word(random_pixel(1'b1));
      settle();
      write_reg(CSR_DEST_X, 12'h800);
      write_reg(CSR_DEST_Y, 12'd0);
      repeat (2) send_word(random_pixel(1'b1));
      settle();

      // back-pressure: result side held off while words keep coming
      write_reg(CSR_DEST_X, 12'd0);
      write_reg(CSR_DEST_Y, 12'd0);
      write_reg(CSR_SPRITE_WIDTH, 12'd16);
      write_reg(CSR_SPRITE_HEIGHT, 12'd16);
      write_reg(CSR_SCREEN_WIDTH, 12'd640);
      write_reg(CSR_SCREEN_HEIGHT, 12'd480);
      hold_asks++;
      steady_sender = 1'b1;
      repeat (48) send_word(random_pixel(1'b1));
      steady_sender = 1'b0;
      settle();

      while (random_items < RANDOM_ITEMS) begin
         random_setup();
         steady_sender = ($urandom_range(0, 3) == 0);
         n = $urandom_range(10, 60);
         repeat (n) begin
            send_word(random_pixel(1'b0));
            random_items++;
         end
         steady_sender = 1'b0;
         settle();
      end

      if (mismatches == 0)
         $display("sprite_alpha_blend_clip regression: pass");
      else
         $display("sprite_alpha_blend_clip regression: fail");
      $finish;
   end

endmodule
